// ===== design/pfdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdl_pkg
// Shared types, register indexes and reset values for the pedal full-down
// position learner.
// ----------------------------------------------------------------------------
package pfdl_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned PosW      = 15;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned StepW     = 16;
  localparam int unsigned TimerW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PEDAL_MAX      = 3'd0,
    CFG_INIT_THRESHOLD = 3'd1,
    CFG_SETTLE_DELAY   = 3'd2,
    CFG_INCREMENT_STEP = 3'd3,
    CFG_DECREMENT_STEP = 3'd4,
    CFG_JUMP_TO_SAMPLE = 3'd5
  } cfg_idx_t;

  localparam logic [CodeW-1:0]  RstPedalMax      = 8'd255;
  localparam logic [CodeW-1:0]  RstInitThreshold = 8'd0;
  localparam logic [TimerW-1:0] RstSettleDelay   = 8'd10;
  localparam logic [StepW-1:0]  RstIncrementStep = 16'd16;
  localparam logic [StepW-1:0]  RstDecrementStep = 16'd16;

  // sample codes at or above this give the decrease path a floor of zero
  localparam logic [SampleW-1:0] SampleSatCode = 16'd1024;

  typedef struct packed {
    logic [TimerW-1:0] timer;
    logic              armed;
    logic              due;
  } settle_t;

  // one tick of a settle timer for a path that runs this tick
  function automatic settle_t settle_tick(input logic [TimerW-1:0] timer,
                                          input logic              armed,
                                          input logic              cond,
                                          input logic [TimerW-1:0] delay);
    settle_t res;
    res.timer = timer;
    res.armed = cond;
    res.due   = 1'b0;
    if (cond) begin
      if (!armed) begin
        res.timer = delay;
      end else if (timer != '0) begin
        res.timer = timer - TimerW'(1);
      end else begin
        res.due = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== design/pedal_full_down_learner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_full_down_learner
// Learns the pedal full-down position from filtered position samples.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_ready is high, and its result is
// registered: all of the learning logic sits between the request port and a
// result register, with a one-entry skid stage behind it, so one more request
// is taken while a result waits on out_ready; in_ready drops once the skid
// stage is full. Sustained rate is one request per cycle while out_ready
// is high. Learned position is at sample*16 scale. Configuration writes
// must only be issued while idle.
module pedal_full_down_learner
  import pfdl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SampleW-1:0]   in_pedal_sample,
  input  logic                 in_learn_enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PosW-1:0]      out_learned_position,
  output logic                 out_position_updated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [StepW-1:0]     cfg_data
);

  logic [CodeW-1:0]  pedal_max_r, init_thr_r;
  logic [TimerW-1:0] settle_delay_r;
  logic [StepW-1:0]  inc_step_r, dec_step_r;
  logic              jump_r;

  logic [PosW-1:0]   learned_pos_r, learned_pos_nxt;
  logic [TimerW-1:0] rise_timer_r, rise_timer_nxt, fall_timer_r, fall_timer_nxt;
  logic              rise_armed_r, rise_armed_nxt, fall_armed_r, fall_armed_nxt;
  logic              updated_nxt;

  logic              out_valid_r, skid_valid_r;
  logic [PosW-1:0]   out_pos_r, skid_pos_r;
  logic              out_upd_r, skid_upd_r;

  logic              acc, take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && in_ready;
  assign take      = out_valid_r && out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedal_max_r    <= RstPedalMax;
      init_thr_r     <= RstInitThreshold;
      settle_delay_r <= RstSettleDelay;
      inc_step_r     <= RstIncrementStep;
      dec_step_r     <= RstDecrementStep;
      jump_r         <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PEDAL_MAX:      pedal_max_r    <= cfg_data[CodeW-1:0];
        CFG_INIT_THRESHOLD: init_thr_r     <= cfg_data[CodeW-1:0];
        CFG_SETTLE_DELAY:   settle_delay_r <= cfg_data[TimerW-1:0];
        CFG_INCREMENT_STEP: inc_step_r     <= cfg_data;
        CFG_DECREMENT_STEP: dec_step_r     <= cfg_data;
        CFG_JUMP_TO_SAMPLE: jump_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // learning datapath
  logic [9:0]      limit;
  logic [13:0]     scaled;
  logic [13:0]     max_pos;
  logic [16:0]     inc_sum;
  logic [PosW-1:0] rise_val;
  logic [PosW-1:0] fall_base;
  logic            dec_under;
  logic [PosW-1:0] dec_val;
  logic [PosW-1:0] fall_val;
  logic            fall_cond;
  settle_t         rise_tick, fall_tick;

  always_comb begin
    limit     = {pedal_max_r, 2'b00};
    scaled    = {in_pedal_sample[9:0], 4'b0000};
    max_pos   = {pedal_max_r, 6'b000000};

    inc_sum   = {2'b00, learned_pos_r} + {1'b0, inc_step_r};
    if (jump_r || (inc_sum >= {3'b000, scaled})) begin
      rise_val = {1'b0, scaled};
    end else begin
      rise_val = inc_sum[PosW-1:0];
    end

    // 16384 wraps to zero in the 14-bit scaled value
    fall_base = (in_pedal_sample >= SampleSatCode) ? '0 : {1'b0, scaled};
    dec_under = {1'b0, learned_pos_r} < dec_step_r;
    dec_val   = learned_pos_r - dec_step_r[PosW-1:0];
    if (dec_under) begin
      fall_val = '0;
    end else if (!dec_val[PosW-1] && (dec_val > fall_base)) begin
      fall_val = dec_val;
    end else begin
      fall_val = fall_base;
    end

    fall_cond = (learned_pos_r > {1'b0, init_thr_r, 6'b000000})
             && (in_pedal_sample > {6'b000000, init_thr_r, 2'b00});

    rise_tick = settle_tick(rise_timer_r, rise_armed_r,
                            in_pedal_sample < {6'b000000, limit}, settle_delay_r);
    fall_tick = settle_tick(fall_timer_r, fall_armed_r, fall_cond, settle_delay_r);

    learned_pos_nxt = learned_pos_r;
    rise_timer_nxt  = rise_timer_r;
    rise_armed_nxt  = rise_armed_r;
    fall_timer_nxt  = fall_timer_r;
    fall_armed_nxt  = fall_armed_r;
    updated_nxt     = 1'b0;

    if (in_learn_enable) begin
      if (in_pedal_sample > {6'b000000, limit}) begin
        learned_pos_nxt = {1'b0, max_pos};
        updated_nxt     = 1'b1;
      end else if ({1'b0, scaled} > learned_pos_r) begin
        rise_timer_nxt = rise_tick.timer;
        rise_armed_nxt = rise_tick.armed;
        if (rise_tick.due) begin
          learned_pos_nxt = rise_val;
          updated_nxt     = 1'b1;
        end
      end else begin
        fall_timer_nxt = fall_tick.timer;
        fall_armed_nxt = fall_tick.armed;
        if (fall_tick.due) begin
          learned_pos_nxt = fall_val;
          updated_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learned_pos_r <= '0;
      rise_timer_r  <= '0;
      rise_armed_r  <= 1'b0;
      fall_timer_r  <= '0;
      fall_armed_r  <= 1'b0;
    end else if (acc) begin
      learned_pos_r <= learned_pos_nxt;
      rise_timer_r  <= rise_timer_nxt;
      rise_armed_r  <= rise_armed_nxt;
      fall_timer_r  <= fall_timer_nxt;
      fall_armed_r  <= fall_armed_nxt;
    end
  end

  // result register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= acc;
        end else begin
          out_valid_r  <= acc;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= acc;
      end else if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid_r) begin
      out_pos_r <= skid_pos_r;
      out_upd_r <= skid_upd_r;
    end else if (acc && (take || !out_valid_r)) begin
      out_pos_r <= learned_pos_nxt;
      out_upd_r <= updated_nxt;
    end
    if (acc && out_valid_r && (!take || skid_valid_r)) begin
      skid_pos_r <= learned_pos_nxt;
      skid_upd_r <= updated_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_learned_position = out_pos_r;
  assign out_position_updated = out_upd_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    !learned_pos_r[PosW-1])
    else $error("learned position out of range");

  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_learn_enable) |=> ($stable(learned_pos_r) && $stable(rise_armed_r)
                                   && $stable(fall_armed_r)))
    else $error("state changed on a request with learning disabled");

  a_no_update_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_learn_enable && !out_valid_r) |=> (out_valid_r && !out_upd_r))
    else $error("update flagged on a request with learning disabled");

endmodule
